FILE: rtl/blic_pkg.sv
// Package for the bracket language interpreter core: tokens, status and phase codes,
// controller states, command and status structs, and character decoding.
// Depends on nothing; the controller, the datapath and the top level import it.
`default_nettype none

package blic_pkg;

  localparam int PROGRAM_DEPTH_DEF = 4096;
  localparam int TAPE_DEPTH_DEF    = 32768;
  localparam int STACK_DEPTH_DEF   = 256;

  // Instructions executed by one resume request before it gives up without a result.
  localparam int STEP_LIMIT = 65536;
  localparam int STEP_W     = $clog2(STEP_LIMIT + 1);

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_RESUME = 1'b1;

  typedef enum logic [2:0] {
    TK_RIGHT = 3'd0,
    TK_LEFT  = 3'd1,
    TK_INC   = 3'd2,
    TK_DEC   = 3'd3,
    TK_OUT   = 3'd4,
    TK_IN    = 3'd5,
    TK_OPEN  = 3'd6,
    TK_CLOSE = 3'd7
  } token_t;

  typedef enum logic [2:0] {
    ST_OUT   = 3'd0,
    ST_NEED  = 3'd1,
    ST_DONE  = 3'd2,
    ST_CLOSE = 3'd3,
    ST_OPEN  = 3'd4,
    ST_PROG  = 3'd5,
    ST_STACK = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    PH_LOAD      = 3'd0,
    PH_RUN       = 3'd1,
    PH_WAIT      = 3'd2,
    PH_DONE      = 3'd3,
    PH_ERR_CLOSE = 3'd4,
    PH_ERR_OPEN  = 3'd5,
    PH_ERR_PROG  = 3'd6,
    PH_ERR_STACK = 3'd7
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LINK_RD,
    S_LINK_EX,
    S_LINK_J1,
    S_LINK_J2,
    S_CLEAR,
    S_FETCH,
    S_EXEC,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic    load;
    logic    link_start;
    logic    push;
    logic    pop;
    logic    jump_wr_open;
    logic    jump_wr_close;
    logic    pc_inc;
    logic    clr_step;
    logic    run_init;
    logic    wait_fill;
    logic    step_clear;
    logic    exec;
    logic    emit;
    status_t emit_status;
  } blic_cmd_t;

  typedef struct packed {
    logic   overflow;
    logic   scan_end;
    token_t tok;
    logic   stack_empty;
    logic   stack_full;
    logic   clr_last;
    logic   step_limit;
    logic   out_busy;
  } blic_stat_t;

  function automatic logic is_command(input logic [7:0] ch);
    logic res;
    case (ch)
      CH_RIGHT, CH_LEFT, CH_INC, CH_DEC,
      CH_OUT, CH_IN, CH_OPEN, CH_CLOSE: res = 1'b1;
      default:                          res = 1'b0;
    endcase
    return res;
  endfunction

  function automatic token_t to_token(input logic [7:0] ch);
    token_t res;
    case (ch)
      CH_RIGHT: res = TK_RIGHT;
      CH_LEFT:  res = TK_LEFT;
      CH_INC:   res = TK_INC;
      CH_DEC:   res = TK_DEC;
      CH_OUT:   res = TK_OUT;
      CH_IN:    res = TK_IN;
      CH_OPEN:  res = TK_OPEN;
      default:  res = TK_CLOSE;
    endcase
    return res;
  endfunction

  function automatic status_t phase_status(input phase_t ph);
    status_t res;
    case (ph)
      PH_ERR_CLOSE: res = ST_CLOSE;
      PH_ERR_OPEN:  res = ST_OPEN;
      PH_ERR_PROG:  res = ST_PROG;
      PH_ERR_STACK: res = ST_STACK;
      default:      res = ST_DONE;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/blic_if.sv
// Valid/ready channel interfaces for the interpreter's request and result sides.
// Depends on nothing; used by the top level and its environment.
`default_nettype none

interface blic_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface blic_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;

  modport source (output valid, output status, output out_byte, input ready);
  modport sink   (input valid, input status, input out_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/bracket_language_interpreter_core.sv
// Top level of the bracket language interpreter: joins the controller and the datapath
// to the request and result channels. Depends on blic_pkg, blic_if, blic_ctrl, blic_dpath.
//
// A load request (mode 0) keeps the character as a token if it is one of the eight commands.
// A resume request (mode 1) runs the program from where it stopped until a '.' gives a byte,
// a ',' asks for input, the program ends, or 65536 instructions have run, in which last case
// no result is returned and the next resume carries on. Each instruction reads the program,
// jump and tape memories through their registered ports and then executes, with at most one
// tape write. A result is registered in the output register, and waits there while the
// result side stalls. The first resume also links the brackets, reading each command and
// writing both jump entries for each close bracket, and then clears the tape, one cell per
// cycle, before the first instruction runs. Bracket and size errors are reported by that
// first resume and repeated by every later one.
`default_nettype none

module bracket_language_interpreter_core
  import blic_pkg::*;
#(
  parameter int PROGRAM_DEPTH = PROGRAM_DEPTH_DEF,
  parameter int TAPE_DEPTH    = TAPE_DEPTH_DEF,
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  blic_in_if.sink   in_chan,
  blic_out_if.source out_chan
);

  blic_cmd_t  cmd;
  blic_stat_t stat;
  logic       in_ready;
  logic       out_valid;
  status_t    out_status;
  logic [7:0] out_byte;

  blic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_chan.valid),
    .in_mode  (in_chan.mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  blic_dpath #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .TAPE_DEPTH    (TAPE_DEPTH),
    .STACK_DEPTH   (STACK_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (in_chan.data_byte),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_chan.ready),
    .out_status (out_status),
    .out_byte   (out_byte)
  );

  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = out_valid;
  assign out_chan.status   = out_status;
  assign out_chan.out_byte = out_byte;

endmodule

`default_nettype wire

FILE: rtl/blic_ctrl.sv
// Controller state machine: request acceptance, program phase, bracket linking,
// tape clearing and the fetch/execute sequence. Depends on blic_pkg.
`default_nettype none

module blic_ctrl
  import blic_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_mode,
  output logic            in_ready,
  input  wire blic_stat_t stat,
  output blic_cmd_t       cmd
);

  ctrl_state_t state, state_next;
  phase_t      phase, phase_next;
  status_t     code, code_next;
  logic        accept;

  assign accept = in_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_LOAD;
      code  <= ST_DONE;
    end else begin
      state <= state_next;
      phase <= phase_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    code_next  = code;
    case (state)
      S_IDLE: begin
        if (accept && (in_mode == MODE_RESUME)) begin
          case (phase)
            PH_LOAD: begin
              if (stat.overflow) begin
                phase_next = PH_ERR_PROG;
                code_next  = ST_PROG;
                state_next = S_EMIT;
              end else begin
                state_next = S_LINK_RD;
              end
            end
            PH_RUN: begin
              state_next = S_FETCH;
            end
            PH_WAIT: begin
              phase_next = PH_RUN;
              state_next = S_FETCH;
            end
            default: begin
              code_next  = phase_status(phase);
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_LINK_RD: begin
        if (stat.scan_end) begin
          if (!stat.stack_empty) begin
            phase_next = PH_ERR_OPEN;
            code_next  = ST_OPEN;
            state_next = S_EMIT;
          end else begin
            state_next = S_CLEAR;
          end
        end else begin
          state_next = S_LINK_EX;
        end
      end
      S_LINK_EX: begin
        case (stat.tok)
          TK_OPEN: begin
            if (stat.stack_full) begin
              phase_next = PH_ERR_STACK;
              code_next  = ST_STACK;
              state_next = S_EMIT;
            end else begin
              state_next = S_LINK_RD;
            end
          end
          TK_CLOSE: begin
            if (stat.stack_empty) begin
              phase_next = PH_ERR_CLOSE;
              code_next  = ST_CLOSE;
              state_next = S_EMIT;
            end else begin
              state_next = S_LINK_J1;
            end
          end
          default: begin
            state_next = S_LINK_RD;
          end
        endcase
      end
      S_LINK_J1: begin
        state_next = S_LINK_J2;
      end
      S_LINK_J2: begin
        state_next = S_LINK_RD;
      end
      S_CLEAR: begin
        if (stat.clr_last) begin
          phase_next = PH_RUN;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (stat.step_limit) begin
          state_next = S_IDLE;
        end else if (stat.scan_end) begin
          phase_next = PH_DONE;
          code_next  = ST_DONE;
          state_next = S_EMIT;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.tok)
          TK_OUT: begin
            code_next  = ST_OUT;
            state_next = S_EMIT;
          end
          TK_IN: begin
            phase_next = PH_WAIT;
            code_next  = ST_NEED;
            state_next = S_EMIT;
          end
          default: begin
            state_next = S_FETCH;
          end
        endcase
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.emit_status = code;
    in_ready        = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load = (phase == PH_LOAD);
          end else begin
            cmd.link_start = (phase == PH_LOAD) && !stat.overflow;
            cmd.step_clear = (phase == PH_RUN) || (phase == PH_WAIT);
            cmd.wait_fill  = (phase == PH_WAIT);
          end
        end
      end
      S_LINK_EX: begin
        cmd.push   = (stat.tok == TK_OPEN) && !stat.stack_full;
        cmd.pop    = (stat.tok == TK_CLOSE) && !stat.stack_empty;
        cmd.pc_inc = cmd.push || ((stat.tok != TK_OPEN) && (stat.tok != TK_CLOSE));
      end
      S_LINK_J1: begin
        cmd.jump_wr_open = 1'b1;
      end
      S_LINK_J2: begin
        cmd.jump_wr_close = 1'b1;
        cmd.pc_inc        = 1'b1;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.run_init = stat.clr_last;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = !stat.out_busy;
      end
      default: begin
        cmd.emit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/blic_dpath.sv
// Datapath: program, jump, bracket stack and tape memories, the position registers,
// the instruction executor and the output register. Depends on blic_pkg.
`default_nettype none

module blic_dpath
  import blic_pkg::*;
#(
  parameter int PROGRAM_DEPTH = PROGRAM_DEPTH_DEF,
  parameter int TAPE_DEPTH    = TAPE_DEPTH_DEF,
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] data_byte,
  input  wire blic_cmd_t  cmd,
  output blic_stat_t      stat,
  output logic            out_valid,
  input  wire logic       out_ready,
  output status_t         out_status,
  output logic [7:0]      out_byte
);

  localparam int PW  = $clog2(PROGRAM_DEPTH);
  localparam int LW  = $clog2(PROGRAM_DEPTH + 1);
  localparam int HW  = $clog2(TAPE_DEPTH);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [2:0]  prog_mem  [PROGRAM_DEPTH];
  logic [PW-1:0] jump_mem [PROGRAM_DEPTH];
  logic [PW-1:0] stack_mem [STACK_DEPTH];
  logic [7:0]  tape_mem  [TAPE_DEPTH];

  logic [LW-1:0]     len;
  logic              overflow;
  logic [LW-1:0]     pc, pc_next;
  logic [HW-1:0]     head, head_next;
  logic [SPW-1:0]    sp;
  logic [HW-1:0]     clr;
  logic [STEP_W-1:0] steps;

  token_t        prog_rd;
  logic [PW-1:0] jump_rd;
  logic [PW-1:0] stack_rd;
  logic [7:0]    tape_rd;

  logic [PW-1:0]  pc_idx;
  logic [SPW-1:0] sp_dec;
  logic           load_ok;
  logic           tape_we;
  logic [HW-1:0]  tape_addr;
  logic [7:0]     tape_wdata;
  logic           jump_we;
  logic [PW-1:0]  jump_addr;
  logic [PW-1:0]  jump_wdata;
  logic [LW-1:0]  jump_target;

  assign pc_idx      = pc[PW-1:0];
  assign sp_dec      = sp - SPW'(1);
  assign load_ok     = cmd.load && is_command(data_byte);
  assign jump_target = LW'(jump_rd) + LW'(1);

  // Program store: at most one token written per load request, read at the code position.
  always_ff @(posedge clk) begin
    if (load_ok && (len < LW'(PROGRAM_DEPTH))) begin
      prog_mem[len[PW-1:0]] <= to_token(data_byte);
    end
    prog_rd <= token_t'(prog_mem[pc_idx]);
  end

  // A matched pair takes two writes: open to close, then close to open.
  always_comb begin
    jump_we    = cmd.jump_wr_open || cmd.jump_wr_close;
    jump_addr  = cmd.jump_wr_open ? stack_rd : pc_idx;
    jump_wdata = cmd.jump_wr_open ? pc_idx : stack_rd;
  end

  always_ff @(posedge clk) begin
    if (jump_we) begin
      jump_mem[jump_addr] <= jump_wdata;
    end
    jump_rd <= jump_mem[pc_idx];
  end

  // Bracket stack: the popped entry is held until both jump writes are done.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[sp[SW-1:0]] <= pc_idx;
    end
    if (cmd.pop) begin
      stack_rd <= stack_mem[sp_dec[SW-1:0]];
    end
  end

  always_comb begin
    tape_we    = 1'b0;
    tape_addr  = head;
    tape_wdata = tape_rd;
    if (cmd.clr_step) begin
      tape_we    = 1'b1;
      tape_addr  = clr;
      tape_wdata = 8'd0;
    end else if (cmd.wait_fill) begin
      tape_we    = 1'b1;
      tape_wdata = data_byte;
    end else if (cmd.exec && (prog_rd == TK_INC)) begin
      tape_we    = 1'b1;
      tape_wdata = tape_rd + 8'd1;
    end else if (cmd.exec && (prog_rd == TK_DEC)) begin
      tape_we    = 1'b1;
      tape_wdata = tape_rd - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_addr] <= tape_wdata;
    end
    tape_rd <= tape_mem[head];
  end

  always_comb begin
    pc_next = pc;
    if (cmd.link_start || cmd.run_init) begin
      pc_next = '0;
    end else if (cmd.pc_inc || cmd.wait_fill) begin
      pc_next = pc + LW'(1);
    end else if (cmd.exec) begin
      case (prog_rd)
        TK_IN:    pc_next = pc;
        TK_OPEN:  pc_next = (tape_rd == 8'd0) ? jump_target : pc + LW'(1);
        TK_CLOSE: pc_next = (tape_rd != 8'd0) ? jump_target : pc + LW'(1);
        default:  pc_next = pc + LW'(1);
      endcase
    end
  end

  // The head wraps at the tape depth in both directions.
  always_comb begin
    head_next = head;
    if (cmd.run_init) begin
      head_next = '0;
    end else if (cmd.exec && (prog_rd == TK_RIGHT)) begin
      head_next = (head == HW'(TAPE_DEPTH - 1)) ? '0 : head + HW'(1);
    end else if (cmd.exec && (prog_rd == TK_LEFT)) begin
      head_next = (head == '0) ? HW'(TAPE_DEPTH - 1) : head - HW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      overflow  <= 1'b0;
      pc        <= '0;
      head      <= '0;
      sp        <= '0;
      clr       <= '0;
      steps     <= '0;
      out_valid <= 1'b0;
    end else begin
      pc   <= pc_next;
      head <= head_next;
      if (load_ok) begin
        if (len < LW'(PROGRAM_DEPTH)) begin
          len <= len + LW'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.link_start) begin
        sp  <= '0;
        clr <= '0;
      end else if (cmd.push) begin
        sp <= sp + SPW'(1);
      end else if (cmd.pop) begin
        sp <= sp_dec;
      end else if (cmd.clr_step) begin
        clr <= clr + HW'(1);
      end
      if (cmd.step_clear || cmd.run_init) begin
        steps <= '0;
      end else if (cmd.exec) begin
        steps <= steps + STEP_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.emit_status;
      out_byte   <= (cmd.emit_status == ST_OUT) ? tape_rd : 8'd0;
    end
  end

  always_comb begin
    stat.overflow    = overflow;
    stat.scan_end    = (pc >= len);
    stat.tok         = prog_rd;
    stat.stack_empty = (sp == '0);
    stat.stack_full  = (sp == SPW'(STACK_DEPTH));
    stat.clr_last    = (clr == HW'(TAPE_DEPTH - 1));
    stat.step_limit  = (steps == STEP_W'(STEP_LIMIT));
    stat.out_busy    = out_valid && !out_ready;
  end

endmodule

`default_nettype wire
